@@ src/pli_pkg.sv @@
package pli_pkg;

  localparam int VALUE_BITS         = 32;
  localparam int MAX_POINTS_DEFAULT = 16;
  localparam int INDEX_BITS         = 4;
  localparam int COUNT_BITS         = 5;
  localparam int STATUS_BITS        = 3;
  localparam int COUNT_MIN          = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STATUS_BITS-1:0] STAT_INTERP = 3'd0;
  localparam logic [STATUS_BITS-1:0] STAT_BELOW  = 3'd1;
  localparam logic [STATUS_BITS-1:0] STAT_ABOVE  = 3'd2;
  localparam logic [STATUS_BITS-1:0] STAT_ZERO   = 3'd3;
  localparam logic [STATUS_BITS-1:0] STAT_SAT    = 3'd4;

  typedef enum logic [1:0] {
    RD_MID  = 2'd0,
    RD_EDGE = 2'd1,
    RD_HI   = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    start;
    logic    write;
    rd_sel_t rd_sel;
    logic    search_step;
    logic    cap_lo;
    logic    diff;
    logic    mul;
    logic    div_init;
    logic    div_step;
    logic    load_out;
  } pli_cmd_t;

  typedef struct packed {
    logic search_done;
    logic clamp;
    logic zero;
    logic div_last;
    logic out_free;
  } pli_stat_t;

endpackage

@@ src/pli_in_if.sv @@
interface pli_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    op;
  logic        [pli_pkg::INDEX_BITS-1:0]   knot_index;
  logic signed [pli_pkg::VALUE_BITS-1:0]   knot_x;
  logic signed [pli_pkg::VALUE_BITS-1:0]   knot_y;
  logic signed [pli_pkg::VALUE_BITS-1:0]   query_x;

  modport source (output valid, op, knot_index, knot_x, knot_y, query_x, input ready);
  modport sink   (input valid, op, knot_index, knot_x, knot_y, query_x, output ready);
endinterface

@@ src/pli_out_if.sv @@
interface pli_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [pli_pkg::VALUE_BITS-1:0]   value;
  logic        [pli_pkg::STATUS_BITS-1:0]  status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

@@ src/piecewise_linear_interpolator_core.sv @@
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    op, knot_index, knot_x, knot_y, query_x
// out_ch   out  valid/ready    value, status
// cfg      in   cfg_we         cfg_wdata (points_in_use)
//
// A knot write does not make the block busy: ready stays high and the slot is written at the transfer.
// A query runs a binary search over the knots in use, each halving step a read (S_RD)
// then a compare (S_CMP) on the single knot memory read port; a clamped query ends there,
// an interpolated one then takes one quotient bit per cycle (33 steps) in the restoring divider.
// Reset is synchronous, active low; the knot memory is not cleared.
// A finished result waits in the output register; the next query stalls only at its end.
module piecewise_linear_interpolator_core #(
  parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pli_in_if.sink                           in_ch,
  pli_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [pli_pkg::COUNT_BITS-1:0]   cfg_wdata
);

  pli_pkg::pli_cmd_t  cmd;
  pli_pkg::pli_stat_t stat;
  logic               in_ready;

  pli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  pli_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .knot_index (in_ch.knot_index),
    .knot_x     (in_ch.knot_x),
    .knot_y     (in_ch.knot_y),
    .query_x    (in_ch.query_x),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_ch.valid),
    .out_value  (out_ch.value),
    .out_status (out_ch.status),
    .out_ready  (out_ch.ready)
  );

  assign in_ch.ready = in_ready;

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_ch.valid && in_ch.ready && in_ch.op == pli_pkg::OP_QUERY) |=> !in_ch.ready)
    else $error("query transfer did not start a search");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_ch.valid && in_ch.ready && in_ch.op == pli_pkg::OP_WRITE) |=> in_ch.ready)
    else $error("knot write left the block busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status <= pli_pkg::STAT_SAT))
    else $error("undefined status code");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == pli_pkg::STAT_SAT) |->
      (out_ch.value == {1'b0, {(pli_pkg::VALUE_BITS-1){1'b1}}} ||
       out_ch.value == {1'b1, {(pli_pkg::VALUE_BITS-1){1'b0}}}))
    else $error("saturated result not at a bound");

endmodule

@@ src/pli_ram.sv @@
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ src/pli_ctrl.sv @@
module pli_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  output pli_pkg::pli_cmd_t  cmd,
  input  pli_pkg::pli_stat_t stat
);

  typedef enum logic [8:0] {
    IDLE     = 9'b000000001,
    S_RD     = 9'b000000010,
    S_CMP    = 9'b000000100,
    E_CAP    = 9'b000001000,
    DIFF     = 9'b000010000,
    MUL      = 9'b000100000,
    DIV_INIT = 9'b001000000,
    DIV      = 9'b010000000,
    FIN      = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == pli_pkg::OP_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = S_RD;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_RD: begin
        if (stat.search_done) begin
          cmd.rd_sel = pli_pkg::RD_EDGE;
          state_nxt  = E_CAP;
        end else begin
          cmd.rd_sel = pli_pkg::RD_MID;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        cmd.search_step = 1'b1;
        state_nxt       = S_RD;
      end
      E_CAP: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_sel = pli_pkg::RD_HI;
        state_nxt  = stat.clamp ? FIN : DIFF;
      end
      DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = MUL;
      end
      MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = stat.zero ? FIN : DIV_INIT;
      end
      DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = DIV;
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = FIN;
        end
      end
      FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

endmodule

@@ src/pli_dp.sv @@
module pli_dp #(
  parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pli_pkg::pli_cmd_t                      cmd,
  output pli_pkg::pli_stat_t                     stat,
  input  logic        [pli_pkg::INDEX_BITS-1:0]  knot_index,
  input  logic signed [pli_pkg::VALUE_BITS-1:0]  knot_x,
  input  logic signed [pli_pkg::VALUE_BITS-1:0]  knot_y,
  input  logic signed [pli_pkg::VALUE_BITS-1:0]  query_x,
  input  logic                                   cfg_we,
  input  logic        [pli_pkg::COUNT_BITS-1:0]  cfg_wdata,
  output logic                                   out_valid,
  output logic signed [pli_pkg::VALUE_BITS-1:0]  out_value,
  output logic        [pli_pkg::STATUS_BITS-1:0] out_status,
  input  logic                                   out_ready
);

  localparam int VB  = pli_pkg::VALUE_BITS;
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 2);
  localparam int MW  = VB + 1;
  localparam int PW  = 2 * MW;
  localparam int QW  = MW;
  localparam int DCW = $clog2(QW);
  localparam int SW  = QW + 2;

  logic [pli_pkg::COUNT_BITS-1:0] count_r;
  logic [CW-1:0]                  n_r, above_r, below_r;
  logic                           found_r;
  logic signed [VB-1:0]           qx_r, x1_r, y1_r;
  logic [MW-1:0]                  dy_mag_r, dx_mag_r, den_mag_r;
  logic                           neg_r, zero_r, ovf_r;
  logic [PW-1:0]                  prod_r;
  logic [MW-1:0]                  rem_r;
  logic [QW-1:0]                  qsh_r;
  logic [DCW-1:0]                 dcnt_r;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [VB-1:0]           out_value_r;
  logic [pli_pkg::STATUS_BITS-1:0] out_status_r;

  logic [31:0]          count_ext, n_clamp;
  logic [CW-1:0]        mid;
  logic                 low, high;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [2*VB-1:0]      ram_rdata;
  logic signed [VB-1:0] rd_x, rd_y;

  logic signed [MW-1:0] x1e, y1e, qxe, x2e, y2e;
  logic                 dy_neg, dx_neg, den_neg;
  logic [MW-1:0]        dy_mag, dx_mag, den_mag;

  logic [MW:0]          trial;
  logic                 trial_ge;
  logic [QW-1:0]        q_eff;
  logic signed [SW-1:0] y1s, qs, sum;
  logic signed [SW-1:0] vmax_s, vmin_s;

  assign count_ext = 32'(count_r);
  assign n_clamp   = (count_ext < 32'(pli_pkg::COUNT_MIN)) ? 32'(pli_pkg::COUNT_MIN) :
                     (count_ext > 32'(MAX_POINTS))         ? 32'(MAX_POINTS) : count_ext;

  assign mid  = CW'(({1'b0, above_r} + {1'b0, below_r}) >> 1);
  assign low  = (below_r == '0);
  assign high = (below_r >= n_r);

  assign ram_we    = cmd.write && (32'(knot_index) < 32'(MAX_POINTS));
  assign ram_waddr = AW'(knot_index);

  always_comb begin
    case (cmd.rd_sel)
      pli_pkg::RD_MID:  ram_raddr = AW'(mid - CW'(1));
      pli_pkg::RD_EDGE: ram_raddr = low ? '0 : AW'(below_r - CW'(1));
      pli_pkg::RD_HI:   ram_raddr = AW'(below_r);
      default:          ram_raddr = '0;
    endcase
  end

  pli_ram #(
    .WIDTH (2 * VB),
    .DEPTH (MAX_POINTS)
  ) u_knots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({knot_x, knot_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_x = ram_rdata[2*VB-1:VB];
  assign rd_y = ram_rdata[VB-1:0];

  assign x1e = {x1_r[VB-1], x1_r};
  assign y1e = {y1_r[VB-1], y1_r};
  assign qxe = {qx_r[VB-1], qx_r};
  assign x2e = {rd_x[VB-1], rd_x};
  assign y2e = {rd_y[VB-1], rd_y};

  assign dy_neg  = (y2e < y1e);
  assign dx_neg  = (qxe < x1e);
  assign den_neg = (x2e < x1e);
  assign dy_mag  = dy_neg  ? MW'(y1e - y2e) : MW'(y2e - y1e);
  assign dx_mag  = dx_neg  ? MW'(x1e - qxe) : MW'(qxe - x1e);
  assign den_mag = den_neg ? MW'(x1e - x2e) : MW'(x2e - x1e);

  assign trial    = {rem_r, qsh_r[QW-1]};
  assign trial_ge = (trial >= {1'b0, den_mag_r});

  assign q_eff  = ovf_r ? '1 : qsh_r;
  assign y1s    = {{(SW-VB){y1_r[VB-1]}}, y1_r};
  assign qs     = {2'b00, q_eff};
  assign sum    = neg_r ? (y1s - qs) : (y1s + qs);
  assign vmax_s = {{(SW-VB+1){1'b0}}, {(VB-1){1'b1}}};
  assign vmin_s = {{(SW-VB+1){1'b1}}, {(VB-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= pli_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r     <= CW'(n_clamp);
      above_r <= CW'(n_clamp + 32'd1);
      below_r <= '0;
      found_r <= 1'b0;
      qx_r    <= query_x;
    end else if (cmd.search_step) begin
      if (qx_r == rd_x) begin
        below_r <= mid;
        found_r <= 1'b1;
      end else if (qx_r < rd_x) begin
        above_r <= mid;
      end else begin
        below_r <= mid;
      end
    end
    if (cmd.cap_lo) begin
      x1_r <= rd_x;
      y1_r <= rd_y;
    end
    if (cmd.diff) begin
      dy_mag_r  <= dy_mag;
      dx_mag_r  <= dx_mag;
      den_mag_r <= den_mag;
      neg_r     <= dy_neg ^ dx_neg ^ den_neg;
      zero_r    <= (rd_x == x1_r);
    end
    if (cmd.mul) begin
      prod_r <= dy_mag_r * dx_mag_r;
    end
    if (cmd.div_init) begin
      ovf_r  <= (prod_r[PW-1:QW] >= den_mag_r);
      rem_r  <= prod_r[PW-1:QW];
      qsh_r  <= prod_r[QW-1:0];
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= trial_ge ? MW'(trial - {1'b0, den_mag_r}) : trial[MW-1:0];
      qsh_r  <= {qsh_r[QW-2:0], trial_ge};
      dcnt_r <= dcnt_r + DCW'(1);
    end
    if (cmd.load_out) begin
      if (low) begin
        out_value_r  <= y1_r;
        out_status_r <= pli_pkg::STAT_BELOW;
      end else if (high) begin
        out_value_r  <= y1_r;
        out_status_r <= pli_pkg::STAT_ABOVE;
      end else if (zero_r) begin
        out_value_r  <= y1_r;
        out_status_r <= pli_pkg::STAT_ZERO;
      end else if (sum > vmax_s) begin
        out_value_r  <= vmax_s[VB-1:0];
        out_status_r <= pli_pkg::STAT_SAT;
      end else if (sum < vmin_s) begin
        out_value_r  <= vmin_s[VB-1:0];
        out_status_r <= pli_pkg::STAT_SAT;
      end else begin
        out_value_r  <= sum[VB-1:0];
        out_status_r <= pli_pkg::STAT_INTERP;
      end
    end
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.search_done = found_r || ((above_r - below_r) <= CW'(1));
  assign stat.clamp       = low || high;
  assign stat.zero        = zero_r;
  assign stat.div_last    = (dcnt_r == DCW'(QW - 1));
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

@@ tb/sv/pli_checker.sv @@
module pli_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  pli_in_if                              in_ch,
  pli_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [pli_pkg::COUNT_BITS-1:0] cfg_wdata,
  output int                             errors,
  output int                             waiting
);
  import pli_pkg::*;

  localparam longint VALUE_MAX = 64'sd2147483647;
  localparam longint VALUE_MIN = -64'sd2147483648;
  localparam logic [127:0] QUOT_CAP = 128'h4000_0000_0000_0000;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  value;
    logic        [STATUS_BITS-1:0] status;
  } lookup_t;

  logic signed [VALUE_BITS-1:0] knot_x_mem [MAX_POINTS_DEFAULT];
  logic signed [VALUE_BITS-1:0] knot_y_mem [MAX_POINTS_DEFAULT];
  logic        [COUNT_BITS-1:0] points_active;
  lookup_t                      lookups_due [$];
  int                           mismatch_count = 0;
  int                           due_count = 0;

  assign errors  = mismatch_count;
  assign waiting = due_count;

  task automatic report_mismatch(string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t pli_checker: %s", $time, what);
    end
    mismatch_count++;
  endtask

  function automatic lookup_t interpolate(logic signed [VALUE_BITS-1:0] qx);
    int           n;
    int           above;
    int           below;
    int           mid;
    int           seg;
    bit           found;
    longint       x1;
    longint       x2;
    longint       y1;
    longint       y2;
    longint       dy;
    longint       dx;
    longint       den;
    longint       r;
    logic [127:0] prod;
    logic [127:0] quot;
    lookup_t      res;
    n = int'(points_active);
    if (n < COUNT_MIN) n = COUNT_MIN;
    if (n > MAX_POINTS_DEFAULT) n = MAX_POINTS_DEFAULT;
    above = n + 1;
    below = 0;
    found = 1'b0;
    seg   = -1;
    while (!found && (above - below > 1)) begin
      mid = (above + below) / 2;
      if (qx == knot_x_mem[mid-1]) begin
        seg   = mid - 1;
        found = 1'b1;
      end else if (qx < knot_x_mem[mid-1]) begin
        above = mid;
      end else begin
        below = mid;
      end
    end
    if (!found) seg = below - 1;

    res.status = STAT_INTERP;
    if (seg < 0) begin
      res.value  = knot_y_mem[0];
      res.status = STAT_BELOW;
    end else if (seg >= n - 1) begin
      res.value  = knot_y_mem[n-1];
      res.status = STAT_ABOVE;
    end else begin
      x1 = knot_x_mem[seg];
      x2 = knot_x_mem[seg+1];
      y1 = knot_y_mem[seg];
      y2 = knot_y_mem[seg+1];
      if (x1 == x2) begin
        res.value  = y1[VALUE_BITS-1:0];
        res.status = STAT_ZERO;
      end else begin
        dy   = y2 - y1;
        dx   = qx - x1;
        den  = x2 - x1;
        prod = 128'(dy < 0 ? -dy : dy) * 128'(dx < 0 ? -dx : dx);
        quot = prod / 128'(den < 0 ? -den : den);
        if (quot > QUOT_CAP) quot = QUOT_CAP;
        if (((dy < 0) != (dx < 0)) != (den < 0)) begin
          r = y1 - longint'(quot[63:0]);
        end else begin
          r = y1 + longint'(quot[63:0]);
        end
        if (r > VALUE_MAX) begin
          r          = VALUE_MAX;
          res.status = STAT_SAT;
        end else if (r < VALUE_MIN) begin
          r          = VALUE_MIN;
          res.status = STAT_SAT;
        end
        res.value = r[VALUE_BITS-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (!rst_n) begin
      points_active = COUNT_RESET;
      lookups_due.delete();
    end else begin
      if (cfg_we) points_active = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        if (lookups_due.size() == 0) begin
          report_mismatch($sformatf("result with none due: value %0d status %0d",
                                    out_ch.value, out_ch.status));
        end else begin
          want = lookups_due.pop_front();
          if (out_ch.value !== want.value) begin
            report_mismatch($sformatf("value %0d, want %0d", out_ch.value, want.value));
          end
          if (out_ch.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_WRITE) begin
          knot_x_mem[in_ch.knot_index] = in_ch.knot_x;
          knot_y_mem[in_ch.knot_index] = in_ch.knot_y;
        end else begin
          lookups_due.push_back(interpolate(in_ch.query_x));
        end
      end
    end
    due_count <= lookups_due.size();
  end
endmodule

@@ tb/sv/piecewise_linear_interpolator_core_tb.sv @@
module piecewise_linear_interpolator_core_tb;
  import pli_pkg::*;

  localparam int ITEM_TARGET   = 1850;
  localparam int QUIET_AFTER   = 1700;
  localparam int SETTLE_CYCLES = 60;
  localparam longint DIR_BASE  = -64'sd1879048192;
  localparam longint DIR_STEP  = 64'sd234881024;
  localparam logic signed [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [COUNT_BITS-1:0]        cfg_wdata;
  int                           check_errors;
  int                           check_waiting;
  bit                           quiet = 1'b0;
  int                           gap_odds = 4;
  int                           sent = 0;
  int                           n_used = COUNT_MIN;
  logic signed [VALUE_BITS-1:0] table_x [MAX_POINTS_DEFAULT];

  pli_in_if  in_ch ();
  pli_out_if out_ch ();

  piecewise_linear_interpolator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pli_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (check_errors),
    .waiting   (check_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(logic op, logic [INDEX_BITS-1:0] idx,
                           logic signed [VALUE_BITS-1:0] kx, logic signed [VALUE_BITS-1:0] ky,
                           logic signed [VALUE_BITS-1:0] qx);
    if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.knot_index <= idx;
    in_ch.knot_x     <= kx;
    in_ch.knot_y     <= ky;
    in_ch.query_x    <= qx;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    sent++;
  endtask

  task automatic put_knot(int idx, logic signed [VALUE_BITS-1:0] kx,
                          logic signed [VALUE_BITS-1:0] ky);
    table_x[idx] = kx;
    send_item(OP_WRITE, idx[INDEX_BITS-1:0], kx, ky, $urandom);
  endtask

  task automatic ask_at(logic signed [VALUE_BITS-1:0] qx);
    send_item(OP_QUERY, INDEX_BITS'($urandom_range(0, MAX_POINTS_DEFAULT - 1)),
              $urandom, $urandom, qx);
  endtask

  // hold off until every lookup is back, then load the count
  task automatic set_points(logic [COUNT_BITS-1:0] count);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (check_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_used = int'(count);
    if (n_used < COUNT_MIN) n_used = COUNT_MIN;
    if (n_used > MAX_POINTS_DEFAULT) n_used = MAX_POINTS_DEFAULT;
  endtask

  function automatic logic signed [VALUE_BITS-1:0] pick_query();
    longint lo;
    longint hi;
    longint pick;
    lo = table_x[0];
    hi = table_x[n_used-1];
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: begin
        if (hi > lo) pick = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
        else pick = lo;
      end
      5, 6: pick = table_x[$urandom_range(0, n_used - 1)];
      7: pick = table_x[$urandom_range(0, n_used - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      8: pick = lo - $urandom_range(1, 1000);
      9: pick = hi + $urandom_range(0, 1000);
      10: pick = $urandom_range(0, 1) ? V_MIN : V_MAX;
      default: pick = $urandom;
    endcase
    return pick[VALUE_BITS-1:0];
  endfunction

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin
    int                           k;
    int unsigned                  step_max;
    int                           y_mode;
    bit                           dups;
    bit                           force_top;
    longint                       xv;
    logic signed [VALUE_BITS-1:0] xk;
    logic signed [VALUE_BITS-1:0] yk;
    logic [COUNT_BITS-1:0]        count;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_WRITE;
    in_ch.knot_index <= '0;
    in_ch.knot_x     <= '0;
    in_ch.knot_y     <= '0;
    in_ch.query_x    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // ascending table with a duplicated abscissa and full-scale ordinates
    set_points(5'd16);
    for (k = 0; k < MAX_POINTS_DEFAULT; k++) begin
      xv = DIR_BASE + ((k == 6) ? 5 : k) * DIR_STEP;
      xk = (k == MAX_POINTS_DEFAULT - 1) ? V_MAX : xv[VALUE_BITS-1:0];
      case (k)
        0:       yk = V_MIN;
        1, 15:   yk = V_MAX;
        default: yk = (k - 8) * 32'sh0100_0000 + 32'sh1234;
      endcase
      put_knot(k, xk, yk);
    end
    ask_at(V_MIN);
    ask_at(V_MAX);
    ask_at(table_x[3]);
    ask_at(table_x[0] + 1);
    ask_at(table_x[1] + 32'sh0700_0000);
    ask_at(table_x[5]);
    ask_at(table_x[6] + 1);
    ask_at('0);
    put_knot(9, -32'sh6000_0000, 32'sh0001_0000);
    ask_at(32'sh0A00_0000);

    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       count = 5'd0;
        1:       count = 5'd1;
        2:       count = 5'd2;
        3:       count = 5'd16;
        4:       count = 5'd17;
        5:       count = 5'd31;
        default: count = COUNT_BITS'($urandom_range(2, 16));
      endcase
      set_points(count);
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);

      if ($urandom_range(0, 9) != 0) begin
        case ($urandom_range(0, 4))
          0:       step_max = 32'd1 << 27;
          1:       step_max = 32'd1 << 16;
          2:       step_max = 32'd1 << 8;
          3:       step_max = 3;
          default: step_max = 0;
        endcase
        y_mode    = $urandom_range(0, 2);
        dups      = ($urandom_range(0, 2) == 0);
        force_top = ($urandom_range(0, 4) == 0);
        xv = -64'sd2147483648 + $urandom_range(0, 32'hFFFF_FFFF - 15 * step_max);
        if (force_top) xv = -64'sd2147483648;
        for (k = 0; k < MAX_POINTS_DEFAULT; k++) begin
          if (step_max == 0) begin
            xk = $urandom;
          end else begin
            xk = xv[VALUE_BITS-1:0];
            xv += (dups && $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, step_max);
          end
          if (force_top && k == MAX_POINTS_DEFAULT - 1) xk = V_MAX;
          case (y_mode)
            0:       yk = $urandom;
            1:       yk = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: yk = k * 37;
          endcase
          put_knot(k, xk, yk);
        end
      end

      repeat ($urandom_range(30, 70)) begin
        if (sent >= QUIET_AFTER) quiet = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          put_knot($urandom_range(0, MAX_POINTS_DEFAULT - 1), $urandom, $urandom);
        end else begin
          ask_at(pick_query());
        end
      end
    end

    quiet = 1'b1;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (check_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (check_errors == 0) begin
      $display("piecewise_linear_interpolator_core_tb: done, clean");
    end else begin
      $display("piecewise_linear_interpolator_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("piecewise_linear_interpolator_core_tb: done, errors");
    $finish;
  end
endmodule
